>>> hdl/prbi_pkg.sv
package prbi_pkg;

    localparam int MAX_REGIONS_DEF  = 8;
    localparam int MAX_VERTICES_DEF = 16;

    localparam int COORD_W = 16;
    localparam int AXIS_W  = COORD_W + 1;
    localparam int PROD_W  = AXIS_W + COORD_W;
    localparam int PROJ_W  = PROD_W + 1;

    // Box corner order: (x1,y1), (x2,y1), (x2,y2), (x1,y2)
    localparam logic [1:0] CORNER_X1Y1 = 2'd0;
    localparam logic [1:0] CORNER_X2Y1 = 2'd1;
    localparam logic [1:0] CORNER_X2Y2 = 2'd2;
    localparam logic [1:0] CORNER_X1Y2 = 2'd3;

    typedef enum logic [1:0] {
        AXIS_EDGE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2
    } axis_sel_t;

    typedef struct packed {
        logic       we;
        logic       box_load;
        logic       cap_a;
        logic       axis_load;
        axis_sel_t  axis_sel;
        logic       issue;
        logic       first;
        logic       is_box;
        logic [1:0] corner;
    } prbi_cmd_t;

    typedef struct packed {
        logic sep;
    } prbi_status_t;

endpackage

>>> hdl/polygon_region_box_intrusion.sv
// Load beat: taken while idle, no result; load beats can follow back to back.
// Test beat: per closed region (n vertices) the n edge axes, then the x and y axes, are
// each projected in turn (region vertices, then the four box corners) and checked.
// A separating axis ends its region at once; a hit ends the test at once.
// The one-read-port vertex memory feeds one projection per cycle.
// Reset (aresetn low, synchronous) empties all regions; vertex memory is not cleared.
module polygon_region_box_intrusion #(
    parameter int MAX_REGIONS  = prbi_pkg::MAX_REGIONS_DEF,
    parameter int MAX_VERTICES = prbi_pkg::MAX_VERTICES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic signed [prbi_pkg::COORD_W-1:0] s_vertex_x,
    input  logic signed [prbi_pkg::COORD_W-1:0] s_vertex_y,
    input  logic                                s_last_vertex,
    input  logic signed [prbi_pkg::COORD_W-1:0] s_box_x1,
    input  logic signed [prbi_pkg::COORD_W-1:0] s_box_y1,
    input  logic signed [prbi_pkg::COORD_W-1:0] s_box_x2,
    input  logic signed [prbi_pkg::COORD_W-1:0] s_box_y2,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_intrudes
);
    import prbi_pkg::*;

    localparam int AW = $clog2(MAX_REGIONS * MAX_VERTICES);

    prbi_cmd_t    cmd;
    prbi_status_t status;
    logic [AW-1:0] waddr, raddr;

    prbi_ctrl #(
        .MAX_REGIONS (MAX_REGIONS),
        .MAX_VERTICES(MAX_VERTICES),
        .AW          (AW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_last_vertex(s_last_vertex),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_intrudes   (m_intrudes),
        .cmd          (cmd),
        .waddr        (waddr),
        .raddr        (raddr),
        .status       (status)
    );

    prbi_datapath #(
        .MAX_REGIONS (MAX_REGIONS),
        .MAX_VERTICES(MAX_VERTICES),
        .AW          (AW)
    ) u_dp (
        .aclk    (aclk),
        .cmd     (cmd),
        .waddr   (waddr),
        .raddr   (raddr),
        .vertex_x(s_vertex_x),
        .vertex_y(s_vertex_y),
        .box_x1  (s_box_x1),
        .box_y1  (s_box_y1),
        .box_x2  (s_box_x2),
        .box_y2  (s_box_y2),
        .status  (status)
    );

    a_write_on_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.we |-> (s_valid && s_ready && !s_mode))
        else $error("vertex write without a load beat");

    a_busy_after_test: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode) |=> !s_ready)
        else $error("input taken right after a test beat");

    a_box_on_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.box_load |-> (s_valid && s_ready && s_mode))
        else $error("box captured without a test beat");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

>>> hdl/prbi_datapath.sv
module prbi_datapath #(
    parameter int MAX_REGIONS  = prbi_pkg::MAX_REGIONS_DEF,
    parameter int MAX_VERTICES = prbi_pkg::MAX_VERTICES_DEF,
    parameter int AW           = $clog2(MAX_REGIONS * MAX_VERTICES)
) (
    input  logic                               aclk,
    input  prbi_pkg::prbi_cmd_t                cmd,
    input  logic [AW-1:0]                      waddr,
    input  logic [AW-1:0]                      raddr,
    input  logic signed [prbi_pkg::COORD_W-1:0] vertex_x,
    input  logic signed [prbi_pkg::COORD_W-1:0] vertex_y,
    input  logic signed [prbi_pkg::COORD_W-1:0] box_x1,
    input  logic signed [prbi_pkg::COORD_W-1:0] box_y1,
    input  logic signed [prbi_pkg::COORD_W-1:0] box_x2,
    input  logic signed [prbi_pkg::COORD_W-1:0] box_y2,
    output prbi_pkg::prbi_status_t             status
);
    import prbi_pkg::*;

    localparam int DEPTH = MAX_REGIONS * MAX_VERTICES;

    logic signed [COORD_W-1:0] mem_x [DEPTH];
    logic signed [COORD_W-1:0] mem_y [DEPTH];
    logic signed [COORD_W-1:0] rd_x_reg, rd_y_reg;
    logic signed [COORD_W-1:0] xa_reg, ya_reg;
    logic signed [COORD_W-1:0] bx1_reg, by1_reg, bx2_reg, by2_reg;
    logic signed [AXIS_W-1:0]  ax_reg, ay_reg, ax_next, ay_next;

    logic       v1_reg, f1_reg, b1_reg;
    logic [1:0] c1_reg;
    logic       v2_reg, f2_reg, b2_reg;
    logic       v3_reg, f3_reg, b3_reg;
    logic signed [COORD_W-1:0] px, py;
    logic signed [PROD_W-1:0]  mx_reg, my_reg;
    logic signed [PROJ_W-1:0]  sum_reg;
    logic signed [PROJ_W-1:0]  min1_reg, max1_reg, min2_reg, max2_reg;

    always_ff @(posedge aclk) begin
        if (cmd.we) begin
            mem_x[waddr] <= vertex_x;
            mem_y[waddr] <= vertex_y;
        end
        rd_x_reg <= mem_x[raddr];
        rd_y_reg <= mem_y[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.box_load) begin
            bx1_reg <= box_x1;
            by1_reg <= box_y1;
            bx2_reg <= box_x2;
            by2_reg <= box_y2;
        end
        if (cmd.cap_a) begin
            xa_reg <= rd_x_reg;
            ya_reg <= rd_y_reg;
        end
        if (cmd.axis_load) begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
        end
    end

    // Edge normal (-dy, dx); rd data holds the edge's end vertex here
    always_comb begin
        case (cmd.axis_sel)
            AXIS_EDGE: begin
                ax_next = AXIS_W'(ya_reg) - AXIS_W'(rd_y_reg);
                ay_next = AXIS_W'(rd_x_reg) - AXIS_W'(xa_reg);
            end
            AXIS_X: begin
                ax_next = AXIS_W'(1);
                ay_next = '0;
            end
            AXIS_Y: begin
                ax_next = '0;
                ay_next = AXIS_W'(1);
            end
            default: begin
                ax_next = '0;
                ay_next = '0;
            end
        endcase
    end

    always_comb begin
        px = rd_x_reg;
        py = rd_y_reg;
        if (b1_reg) begin
            case (c1_reg)
                CORNER_X1Y1: begin px = bx1_reg; py = by1_reg; end
                CORNER_X2Y1: begin px = bx2_reg; py = by1_reg; end
                CORNER_X2Y2: begin px = bx2_reg; py = by2_reg; end
                CORNER_X1Y2: begin px = bx1_reg; py = by2_reg; end
                default:     begin px = bx1_reg; py = by1_reg; end
            endcase
        end
    end

    // Projection pipe: operand select, products, sum, min/max
    always_ff @(posedge aclk) begin
        v1_reg <= cmd.issue;
        f1_reg <= cmd.first;
        b1_reg <= cmd.is_box;
        c1_reg <= cmd.corner;
        v2_reg <= v1_reg;
        f2_reg <= f1_reg;
        b2_reg <= b1_reg;
        mx_reg <= PROD_W'(ax_reg) * PROD_W'(px);
        my_reg <= PROD_W'(ay_reg) * PROD_W'(py);
        v3_reg <= v2_reg;
        f3_reg <= f2_reg;
        b3_reg <= b2_reg;
        sum_reg <= PROJ_W'(mx_reg) + PROJ_W'(my_reg);
        if (v3_reg) begin
            if (b3_reg) begin
                if (f3_reg || sum_reg < min2_reg) min2_reg <= sum_reg;
                if (f3_reg || sum_reg > max2_reg) max2_reg <= sum_reg;
            end else begin
                if (f3_reg || sum_reg < min1_reg) min1_reg <= sum_reg;
                if (f3_reg || sum_reg > max1_reg) max1_reg <= sum_reg;
            end
        end
    end

    assign status.sep = !((max1_reg >= min2_reg) && (max2_reg >= min1_reg));

endmodule

>>> hdl/prbi_ctrl.sv
module prbi_ctrl #(
    parameter int MAX_REGIONS  = prbi_pkg::MAX_REGIONS_DEF,
    parameter int MAX_VERTICES = prbi_pkg::MAX_VERTICES_DEF,
    parameter int AW           = $clog2(MAX_REGIONS * MAX_VERTICES)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_mode,
    input  logic                   s_last_vertex,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_intrudes,
    output prbi_pkg::prbi_cmd_t    cmd,
    output logic [AW-1:0]          waddr,
    output logic [AW-1:0]          raddr,
    input  prbi_pkg::prbi_status_t status
);
    import prbi_pkg::*;

    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int KW  = $clog2(MAX_VERTICES + 4);
    localparam int RCW = $clog2(MAX_REGIONS + 1);
    localparam int RIW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int BW  = AW + 1;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_REGION = 10'b0000000010,
        ST_ASTART = 10'b0000000100,
        ST_EDGE_A = 10'b0000001000,
        ST_EDGE_B = 10'b0000010000,
        ST_AXIS   = 10'b0000100000,
        ST_PROJ   = 10'b0001000000,
        ST_DRAIN  = 10'b0010000000,
        ST_CHECK  = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [RCW-1:0] closed_reg, closed_next;
    logic [VCW-1:0] building_reg, building_next, bnew;
    logic [VCW-1:0] sizes_reg [MAX_REGIONS];
    logic [BW-1:0]  lbase_reg, lbase_next, tbase_reg, tbase_next;
    logic [RCW-1:0] r_reg, r_next;
    logic [KW-1:0]  a_reg, a_next, k_reg, k_next;
    logic [1:0]     drain_reg, drain_next;
    logic           hit_reg, hit_next;
    logic           mv_reg, mv_next, mi_reg, mi_next;
    logic [VCW-1:0] n_cur;
    logic [KW-1:0]  n_k, a_inc, k_off, off;
    logic [BW-1:0]  wsum, rsum;
    logic           accept, size_we;

    assign accept = s_valid && s_ready;
    assign n_cur  = sizes_reg[r_reg[RIW-1:0]];
    assign n_k    = KW'(n_cur);
    assign a_inc  = a_reg + KW'(1);
    assign k_off  = k_reg - n_k;
    assign wsum   = lbase_reg + BW'(building_reg);
    assign waddr  = wsum[AW-1:0];
    assign rsum   = tbase_reg + BW'(off);
    assign raddr  = rsum[AW-1:0];

    always_comb begin
        case (state_reg)
            ST_EDGE_A: off = a_reg;
            ST_EDGE_B: off = (a_inc == n_k) ? '0 : a_inc;
            default:   off = k_reg;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        closed_next   = closed_reg;
        building_next = building_reg;
        lbase_next    = lbase_reg;
        tbase_next    = tbase_reg;
        r_next        = r_reg;
        a_next        = a_reg;
        k_next        = k_reg;
        drain_next    = drain_reg;
        hit_next      = hit_reg;
        mv_next       = (m_valid && m_ready) ? 1'b0 : mv_reg;
        mi_next       = mi_reg;
        size_we       = 1'b0;
        bnew          = building_reg;
        s_ready       = (state_reg == ST_IDLE);
        cmd           = '0;
        cmd.axis_sel  = AXIS_EDGE;

        case (state_reg)
            ST_IDLE: begin
                if (accept && !s_mode) begin
                    if (closed_reg < RCW'(MAX_REGIONS)) begin
                        if (building_reg < VCW'(MAX_VERTICES)) begin
                            cmd.we = 1'b1;
                            bnew   = building_reg + VCW'(1);
                        end
                        if (s_last_vertex) begin
                            size_we       = 1'b1;
                            closed_next   = closed_reg + RCW'(1);
                            lbase_next    = lbase_reg + BW'(MAX_VERTICES);
                            building_next = '0;
                        end else begin
                            building_next = bnew;
                        end
                    end
                end else if (accept) begin
                    cmd.box_load = 1'b1;
                    r_next       = '0;
                    tbase_next   = '0;
                    hit_next     = 1'b0;
                    state_next   = ST_REGION;
                end
            end
            ST_REGION: begin
                if (r_reg == closed_reg) begin
                    state_next = ST_DONE;
                end else if (n_cur == '0) begin
                    r_next     = r_reg + RCW'(1);
                    tbase_next = tbase_reg + BW'(MAX_VERTICES);
                end else begin
                    a_next     = '0;
                    state_next = ST_ASTART;
                end
            end
            ST_ASTART: begin
                state_next = (a_reg < n_k) ? ST_EDGE_A : ST_AXIS;
            end
            ST_EDGE_A: begin
                state_next = ST_EDGE_B;
            end
            ST_EDGE_B: begin
                cmd.cap_a  = 1'b1;
                state_next = ST_AXIS;
            end
            ST_AXIS: begin
                cmd.axis_load = 1'b1;
                if (a_reg < n_k)       cmd.axis_sel = AXIS_EDGE;
                else if (a_reg == n_k) cmd.axis_sel = AXIS_X;
                else                   cmd.axis_sel = AXIS_Y;
                k_next     = '0;
                state_next = ST_PROJ;
            end
            ST_PROJ: begin
                cmd.issue  = 1'b1;
                cmd.is_box = (k_reg >= n_k);
                cmd.corner = k_off[1:0];
                cmd.first  = (k_reg == '0) || (k_reg == n_k);
                k_next     = k_reg + KW'(1);
                if (k_reg == n_k + KW'(3)) begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait until the last beat reaches min/max
                drain_next = drain_reg + 2'd1;
                if (drain_reg == 2'd2) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.sep) begin
                    r_next     = r_reg + RCW'(1);
                    tbase_next = tbase_reg + BW'(MAX_VERTICES);
                    state_next = ST_REGION;
                end else if (a_reg == n_k + KW'(1)) begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    a_next     = a_inc;
                    state_next = ST_ASTART;
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mi_next    = hit_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            closed_reg   <= '0;
            building_reg <= '0;
            lbase_reg    <= '0;
            mv_reg       <= 1'b0;
            for (int i = 0; i < MAX_REGIONS; i++) sizes_reg[i] <= '0;
        end else begin
            state_reg    <= state_next;
            closed_reg   <= closed_next;
            building_reg <= building_next;
            lbase_reg    <= lbase_next;
            mv_reg       <= mv_next;
            if (size_we) sizes_reg[closed_reg[RIW-1:0]] <= bnew;
        end
    end

    always_ff @(posedge aclk) begin
        tbase_reg <= tbase_next;
        r_reg     <= r_next;
        a_reg     <= a_next;
        k_reg     <= k_next;
        drain_reg <= drain_next;
        hit_reg   <= hit_next;
        mi_reg    <= mi_next;
    end

    assign m_valid    = mv_reg;
    assign m_intrudes = mi_reg;

endmodule
